>>> design/pse_pkg.sv
// Shared types, constants and byte helper functions for the PNG stored-deflate encoder.
package pse_pkg;

	localparam int unsigned BLOCK_LEN_MAX = 65535;
	localparam int unsigned MAX_SIDE = 16384;
	localparam int unsigned SIDE_W = 15;
	localparam int unsigned RAW_W = 31;
	localparam int unsigned ROW_W = 17;
	localparam int unsigned FILL_W = 16;
	localparam int unsigned ADLER_MOD = 65521;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [7:0] ZLIB_CMF = 8'h78;
	localparam logic [7:0] ZLIB_FLG = 8'h01;

	localparam logic CFG_WIDTH = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_SIG,
		PH_IHDR_LEN,
		PH_IHDR_TAG,
		PH_IHDR_DATA,
		PH_IHDR_CRC,
		PH_IDAT_LEN,
		PH_IDAT_TAG,
		PH_ZLIB,
		PH_HDR_F,
		PH_FILTER,
		PH_HDR_D,
		PH_DATA,
		PH_ADLER,
		PH_IDAT_CRC,
		PH_IEND_LEN,
		PH_IEND_TAG,
		PH_IEND_CRC
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] idx;
		logic       emit;
		logic       load;
	} pse_cmd_t;

	typedef struct packed {
		logic header_sent;
		logic fill_zero;
		logic fill_one;
		logic row_start;
		logic raw_one;
		logic out_free;
	} pse_sts_t;

	function automatic logic [3:0] last_idx(input phase_t ph);
		logic [3:0] r;
		r = 4'd0;
		unique case (ph)
			PH_SIG:       r = 4'd7;
			PH_IHDR_DATA: r = 4'd12;
			PH_ZLIB:      r = 4'd1;
			PH_HDR_F, PH_HDR_D: r = 4'd4;
			PH_IDLE, PH_FILTER, PH_DATA: r = 4'd0;
			default:      r = 4'd3;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sig_byte(input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		unique case (i)
			3'd0: r = 8'h89;
			3'd1: r = 8'h50;
			3'd2: r = 8'h4E;
			3'd3: r = 8'h47;
			3'd4: r = 8'h0D;
			3'd5: r = 8'h0A;
			3'd6: r = 8'h1A;
			default: r = 8'h0A;
		endcase
		return r;
	endfunction

	// big-endian byte of a 32-bit word
	function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] i);
		logic [7:0] r;
		r = 8'h00;
		unique case (i)
			2'd0: r = w[31:24];
			2'd1: r = w[23:16];
			2'd2: r = w[15:8];
			default: r = w[7:0];
		endcase
		return r;
	endfunction

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

>>> design/png_stored_encoder_core.sv
// Top level of the PNG stored-deflate encoder: controller, datapath and stream ports.
// Each input byte produces one or more output bytes, one per cycle through the output register
// while m_axis_tready does not hold it. An accepted transaction emits a pixel byte, after a
// filter byte at a row start and a stored block header at a block start; the first byte of a
// file is led by signature, IHDR, IDAT and zlib header; the last adds Adler-32, CRC and IEND.
// Reset (arst_n low) returns to the state before a file header with width and height of 1.
module png_stored_encoder_core import pse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,  // [7:0] data_byte
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // [7:0] out_byte
	output logic              m_axis_tlast,  // last_of_run
	output logic              m_axis_tuser,  // [0] end_of_file
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [SIDE_W-1:0] cfg_data
);

	pse_cmd_t cmd;
	pse_sts_t sts;

	pse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pse_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_eof   (m_axis_tuser)
	);

endmodule

>>> design/pse_ctrl.sv
// Controller: sequences the output bytes of one input transaction.
module pse_ctrl import pse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pse_sts_t sts,
	output pse_cmd_t cmd
);

	phase_t     state_q, state_d;
	logic [3:0] idx_q;
	logic       emit;
	logic       at_last;

	assign emit = (state_q != PH_IDLE) && sts.out_free;
	assign at_last = (idx_q == last_idx(state_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PH_IDLE: begin
				if (in_valid) begin
					if (!sts.header_sent) state_d = PH_SIG;
					else if (sts.row_start) state_d = sts.fill_zero ? PH_HDR_F : PH_FILTER;
					else state_d = sts.fill_zero ? PH_HDR_D : PH_DATA;
				end
			end
			PH_SIG:       if (emit && at_last) state_d = PH_IHDR_LEN;
			PH_IHDR_LEN:  if (emit && at_last) state_d = PH_IHDR_TAG;
			PH_IHDR_TAG:  if (emit && at_last) state_d = PH_IHDR_DATA;
			PH_IHDR_DATA: if (emit && at_last) state_d = PH_IHDR_CRC;
			PH_IHDR_CRC:  if (emit && at_last) state_d = PH_IDAT_LEN;
			PH_IDAT_LEN:  if (emit && at_last) state_d = PH_IDAT_TAG;
			PH_IDAT_TAG:  if (emit && at_last) state_d = PH_ZLIB;
			PH_ZLIB:      if (emit && at_last) state_d = PH_HDR_F;
			PH_HDR_F:     if (emit && at_last) state_d = PH_FILTER;
			PH_FILTER:    if (emit) state_d = sts.fill_one ? PH_HDR_D : PH_DATA;
			PH_HDR_D:     if (emit && at_last) state_d = PH_DATA;
			PH_DATA:      if (emit) state_d = sts.raw_one ? PH_ADLER : PH_IDLE;
			PH_ADLER:     if (emit && at_last) state_d = PH_IDAT_CRC;
			PH_IDAT_CRC:  if (emit && at_last) state_d = PH_IEND_LEN;
			PH_IEND_LEN:  if (emit && at_last) state_d = PH_IEND_TAG;
			PH_IEND_TAG:  if (emit && at_last) state_d = PH_IEND_CRC;
			PH_IEND_CRC:  if (emit && at_last) state_d = PH_IDLE;
			default:      state_d = PH_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == PH_IDLE);
		cmd.phase = state_q;
		cmd.idx   = idx_q;
		cmd.emit  = emit;
		cmd.load  = (state_q == PH_IDLE) && in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			idx_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) idx_q <= 4'd0;
			else if (emit) idx_q <= idx_q + 4'd1;
		end
	end

endmodule

>>> design/pse_dp.sv
// Datapath: byte selection, CRC-32, Adler-32, counters, sizes and output register.
module pse_dp import pse_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [SIDE_W-1:0]   cfg_data,
	input  logic [7:0]          in_data,
	input  pse_cmd_t            cmd,
	output pse_sts_t            sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_data,
	output logic                out_last,
	output logic                out_eof
);

	logic [SIDE_W-1:0] width_q, height_q, side_clamped;
	logic [RAW_W-1:0]  raw_s1;
	logic [14:0]       blocks_s2;
	logic [31:0]       idat_len_s3;
	logic [31:0]       blk_sum, blk_t;
	logic [31:0]       crc_q;
	logic [15:0]       adl_lo_q, adl_hi_q;
	logic [ROW_W-1:0]  row_byte_q, row_next;
	logic [FILL_W-1:0] fill_q, blk_len;
	logic [RAW_W-1:0]  raw_left_q;
	logic              hdr_sent_q;
	logic [7:0]        data_q;
	logic              valid_q, last_q, eof_q;
	logic [7:0]        obyte_q;
	logic [7:0]        b;
	logic              feed;
	logic              at_last;
	logic [16:0]       lo_sum, lo_mod, hi_sum, hi_mod;
	logic              final_blk;

	// clamp a written side into one..MAX_SIDE
	always_comb begin
		side_clamped = cfg_data;
		if (cfg_data == '0) side_clamped = SIDE_W'(1);
		else if (cfg_data > SIDE_W'(MAX_SIDE)) side_clamped = SIDE_W'(MAX_SIDE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(1);
			height_q <= SIDE_W'(1);
		end else if (cfg_we && !hdr_sent_q) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= side_clamped;
				CFG_HEIGHT: height_q <= side_clamped;
				default: ;
			endcase
		end
	end

	// size pipeline: raw bytes, block count by reciprocal of 65535, IDAT length
	assign blk_t   = {1'b0, raw_s1} + 32'(BLOCK_LEN_MAX - 1);
	assign blk_sum = blk_t + {16'd0, blk_t[31:16]} + 32'd1;

	always_ff @(posedge clk) begin
		raw_s1      <= RAW_W'(height_q * {width_q, 2'b01});
		blocks_s2   <= blk_sum[30:16];
		idat_len_s3 <= {1'b0, raw_s1} + 32'(blocks_s2) * 32'd5 + 32'd6;
	end

	assign blk_len   = (raw_left_q < RAW_W'(BLOCK_LEN_MAX)) ? raw_left_q[FILL_W-1:0]
		: FILL_W'(BLOCK_LEN_MAX);
	assign final_blk = (raw_left_q <= RAW_W'(BLOCK_LEN_MAX));
	assign at_last   = (cmd.idx == last_idx(cmd.phase));

	always_comb begin
		b    = 8'h00;
		feed = 1'b1;
		unique case (cmd.phase) inside
			PH_SIG: begin
				b    = sig_byte(cmd.idx[2:0]);
				feed = 1'b0;
			end
			PH_IHDR_LEN: begin
				b    = word_byte(32'd13, cmd.idx[1:0]);
				feed = 1'b0;
			end
			PH_IHDR_TAG: b = word_byte(32'h49484452, cmd.idx[1:0]);
			PH_IHDR_DATA: begin
				case (cmd.idx) inside
					4'd0, 4'd1, 4'd2, 4'd3:
						b = word_byte({17'd0, width_q}, cmd.idx[1:0]);
					4'd4, 4'd5, 4'd6, 4'd7:
						b = word_byte({17'd0, height_q}, cmd.idx[1:0]);
					4'd8:    b = 8'd8;
					4'd9:    b = 8'd6;
					default: b = 8'd0;
				endcase
			end
			PH_IHDR_CRC, PH_IDAT_CRC, PH_IEND_CRC: begin
				b    = word_byte(~crc_q, cmd.idx[1:0]);
				feed = 1'b0;
			end
			PH_IDAT_LEN: begin
				b    = word_byte(idat_len_s3, cmd.idx[1:0]);
				feed = 1'b0;
			end
			PH_IDAT_TAG: b = word_byte(32'h49444154, cmd.idx[1:0]);
			PH_ZLIB:     b = (cmd.idx[0]) ? ZLIB_FLG : ZLIB_CMF;
			PH_HDR_F, PH_HDR_D: begin
				case (cmd.idx)
					4'd0:    b = {7'd0, final_blk};
					4'd1:    b = blk_len[7:0];
					4'd2:    b = blk_len[15:8];
					4'd3:    b = ~blk_len[7:0];
					default: b = ~blk_len[15:8];
				endcase
			end
			PH_FILTER:   b = 8'h00;
			PH_DATA:     b = data_q;
			PH_ADLER:    b = word_byte({adl_hi_q, adl_lo_q}, cmd.idx[1:0]);
			PH_IEND_LEN: begin
				b    = 8'h00;
				feed = 1'b0;
			end
			PH_IEND_TAG: b = word_byte(32'h49454E44, cmd.idx[1:0]);
			default:     feed = 1'b0;
		endcase
	end

	assign lo_sum   = {1'b0, adl_lo_q} + {9'd0, b};
	assign lo_mod   = (lo_sum >= 17'(ADLER_MOD)) ? lo_sum - 17'(ADLER_MOD) : lo_sum;
	assign hi_sum   = {1'b0, adl_hi_q} + lo_mod;
	assign hi_mod   = (hi_sum >= 17'(ADLER_MOD)) ? hi_sum - 17'(ADLER_MOD) : hi_sum;
	assign row_next = row_byte_q + ROW_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) data_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			adl_lo_q   <= 16'd1;
			adl_hi_q   <= 16'd0;
			row_byte_q <= '0;
			fill_q     <= '0;
			raw_left_q <= '0;
			hdr_sent_q <= 1'b0;
			valid_q    <= 1'b0;
			last_q     <= 1'b0;
			eof_q      <= 1'b0;
			obyte_q    <= 8'h00;
		end else begin
			if (out_ready && !cmd.emit) valid_q <= 1'b0;
			if (cmd.emit) begin
				valid_q <= 1'b1;
				obyte_q <= b;
				last_q  <= ((cmd.phase == PH_DATA) && (raw_left_q != RAW_W'(1)))
					|| ((cmd.phase == PH_IEND_CRC) && at_last);
				eof_q   <= (cmd.phase == PH_IEND_CRC) && at_last;
				if (feed) crc_q <= crc_step(crc_q, b);
				// close a chunk: restart the CRC
				if ((cmd.phase == PH_IHDR_CRC || cmd.phase == PH_IDAT_CRC
						|| cmd.phase == PH_IEND_CRC) && at_last)
					crc_q <= CRC_INIT;
				unique case (cmd.phase) inside
					PH_ZLIB: begin
						if (at_last) begin
							raw_left_q <= raw_s1;
							hdr_sent_q <= 1'b1;
							adl_lo_q   <= 16'd1;
							adl_hi_q   <= 16'd0;
							row_byte_q <= '0;
							fill_q     <= '0;
						end
					end
					PH_HDR_F, PH_HDR_D: begin
						if (at_last) fill_q <= blk_len;
					end
					PH_FILTER, PH_DATA: begin
						adl_lo_q <= lo_mod[15:0];
						adl_hi_q <= hi_mod[15:0];
						if (raw_left_q != '0) raw_left_q <= raw_left_q - RAW_W'(1);
						if (fill_q != '0) fill_q <= fill_q - FILL_W'(1);
						if (cmd.phase == PH_DATA) begin
							if (row_next >= {width_q, 2'b00}) row_byte_q <= '0;
							else row_byte_q <= row_next;
						end
					end
					PH_ADLER: begin
						if (at_last) begin
							adl_lo_q   <= 16'd1;
							adl_hi_q   <= 16'd0;
							row_byte_q <= '0;
							fill_q     <= '0;
							raw_left_q <= '0;
						end
					end
					PH_IEND_CRC: begin
						if (at_last) hdr_sent_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		sts.header_sent = hdr_sent_q;
		sts.fill_zero   = (fill_q == '0);
		sts.fill_one    = (fill_q == FILL_W'(1));
		sts.row_start   = (row_byte_q == '0);
		sts.raw_one     = (raw_left_q == RAW_W'(1));
		sts.out_free    = !valid_q || out_ready;
	end

	assign out_valid = valid_q;
	assign out_data  = obyte_q;
	assign out_last  = last_q;
	assign out_eof   = eof_q;

endmodule
